// ----- rtl/bsa_pkg.sv -----
package bsa_pkg;

    localparam int MAX_BLOCKS      = 16;
    localparam int SLOTS_PER_BLOCK = 64;

    // The lowest free index is found one byte-wide window at a time.
    localparam int LANE_W   = 8;
    localparam int NUM_WIN  = SLOTS_PER_BLOCK / LANE_W;
    localparam int WIN_W    = $clog2(NUM_WIN);
    localparam int OFF_W    = $clog2(LANE_W);
    localparam int IDX_W    = $clog2(SLOTS_PER_BLOCK);
    localparam int BLK_W    = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
    localparam int CNT_W    = $clog2(MAX_BLOCKS + 1);
    localparam int USED_W   = $clog2(MAX_BLOCKS * SLOTS_PER_BLOCK + 1);

    localparam int SLOT_W   = 10;
    localparam int STATUS_W = 2;
    localparam int LIVE_W   = 11;
    localparam int OPEN_W   = 5;

    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    localparam logic [STATUS_W-1:0] STATUS_OK   = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_FULL = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_BAD  = 2'd2;

    typedef struct packed {
        logic              command;
        logic [SLOT_W-1:0] slot;
    } req_t;

    typedef struct packed {
        logic [SLOT_W-1:0]   granted_slot;
        logic [STATUS_W-1:0] status;
        logic [LIVE_W-1:0]   live_count;
        logic [OPEN_W-1:0]   open_blocks;
    } rsp_t;

    // One bit update of the free map.
    typedef struct packed {
        logic             en;
        logic [BLK_W-1:0] blk;
        logic [IDX_W-1:0] idx;
        logic             set;
    } map_wr_t;

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_SEARCH = 4'b0010,
        S_FIND   = 4'b0100,
        S_FREE   = 4'b1000
    } state_t;

endpackage

// ----- rtl/bitmap_slot_allocator.sv -----
// Slot allocator over blocks of 64 slots, each block tracked by a free-bit word.
// A request is presented on request with start high; it is taken at the rising
// edge where start is high and busy is low. busy stays high while it is worked.
// An allocate walks the open blocks backward from the newest, one block per
// cycle, and opens one more block when all of them are full. The chosen word
// is then scanned for its lowest free bit one 8-bit window per cycle through a
// single shared priority encoder. A free checks the range and the slot's bit
// and sets it back when the slot was in use.
// Exactly one result follows each request: result is valid for the single
// cycle in which done is high, and it must be taken then, since the receiver
// cannot hold it off. A new request may be taken in that same cycle.
// An allocate refused because the store is full ends after its walk over
// the blocks and has no window steps.
// Reset marks every slot free, leaves one block open and the live count zero;
// no clearing pass is needed, so requests are taken right after reset.
module bitmap_slot_allocator
    import bsa_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic start,
    input  req_t request,
    output logic busy,
    output logic done,
    output rsp_t result
);

    state_t              state_reg, state_next;
    logic [SLOT_W-1:0]   slot_reg, slot_next;
    logic [BLK_W-1:0]    blk_reg, blk_next;
    logic [WIN_W-1:0]    win_reg, win_next;
    logic [CNT_W-1:0]    open_reg, open_next;
    logic [USED_W-1:0]   used_reg, used_next;
    logic [SLOT_W-1:0]   granted_reg, granted_next;
    logic [STATUS_W-1:0] status_reg, status_next;
    logic                done_reg, done_next;

    logic [SLOTS_PER_BLOCK-1:0] rd_word;
    map_wr_t                    wr;
    logic                       lane_hit;
    logic [OFF_W-1:0]           lane_off;

    // Block and index fields of the slot being freed.
    logic [SLOT_W-IDX_W-1:0] free_blk;
    logic [IDX_W-1:0]        free_idx;

    assign free_blk = slot_reg[SLOT_W-1:IDX_W];
    assign free_idx = slot_reg[IDX_W-1:0];

    bsa_store u_store (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_blk  (blk_reg),
        .rd_word (rd_word),
        .wr      (wr)
    );

    bsa_lsb_unit u_lsb (
        .word (rd_word),
        .win  (win_reg),
        .hit  (lane_hit),
        .off  (lane_off)
    );

    always_comb
    begin
        state_next   = state_reg;
        slot_next    = slot_reg;
        blk_next     = blk_reg;
        win_next     = win_reg;
        open_next    = open_reg;
        used_next    = used_reg;
        granted_next = granted_reg;
        status_next  = status_reg;
        done_next    = 1'b0;
        wr           = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    slot_next = request.slot;
                    if (request.command == CMD_FREE)
                    begin
                        // The address is only used once the range check passes.
                        blk_next   = BLK_W'(request.slot[SLOT_W-1:IDX_W]);
                        state_next = S_FREE;
                    end
                    else
                    begin
                        // Start the backward walk at the newest open block.
                        blk_next   = BLK_W'(open_reg - 1'b1);
                        state_next = S_SEARCH;
                    end
                end
            end

            S_SEARCH:
            begin
                if (rd_word != '0)
                begin
                    win_next   = '0;
                    state_next = S_FIND;
                end
                else if (blk_reg == '0)
                begin
                    if (open_reg < CNT_W'(MAX_BLOCKS))
                    begin
                        // A block that was never opened still has every bit set.
                        blk_next   = BLK_W'(open_reg);
                        open_next  = open_reg + 1'b1;
                        win_next   = '0;
                        state_next = S_FIND;
                    end
                    else
                    begin
                        granted_next = '0;
                        status_next  = STATUS_FULL;
                        done_next    = 1'b1;
                        state_next   = S_IDLE;
                    end
                end
                else
                begin
                    blk_next = blk_reg - 1'b1;
                end
            end

            S_FIND:
            begin
                if (lane_hit)
                begin
                    wr.en        = 1'b1;
                    wr.blk       = blk_reg;
                    wr.idx       = {win_reg, lane_off};
                    wr.set       = 1'b0;
                    used_next    = used_reg + 1'b1;
                    granted_next = SLOT_W'({blk_reg, win_reg, lane_off});
                    status_next  = STATUS_OK;
                    done_next    = 1'b1;
                    state_next   = S_IDLE;
                end
                else
                begin
                    win_next = win_reg + 1'b1;
                end
            end

            S_FREE:
            begin
                granted_next = '0;
                done_next    = 1'b1;
                state_next   = S_IDLE;
                // The open count never exceeds the block limit, so one check
                // covers both range conditions.
                if (int'(free_blk) >= int'(open_reg))
                begin
                    status_next = STATUS_BAD;
                end
                else if (rd_word[free_idx])
                begin
                    status_next = STATUS_BAD;
                end
                else
                begin
                    wr.en       = 1'b1;
                    wr.blk      = blk_reg;
                    wr.idx      = free_idx;
                    wr.set      = 1'b1;
                    used_next   = used_reg - 1'b1;
                    status_next = STATUS_OK;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            open_reg  <= CNT_W'(1);
            used_reg  <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            open_reg  <= open_next;
            used_reg  <= used_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        slot_reg    <= slot_next;
        blk_reg     <= blk_next;
        win_reg     <= win_next;
        granted_reg <= granted_next;
        status_reg  <= status_next;
    end

    // The counters settle at the same edge that raises done and cannot move
    // again before the done cycle ends, so they are shown directly.
    assign busy = (state_reg != S_IDLE);
    assign done = done_reg;

    assign result.granted_slot = granted_reg;
    assign result.status       = status_reg;
    assign result.live_count   = LIVE_W'(used_reg);
    assign result.open_blocks  = OPEN_W'(open_reg);

endmodule

// ----- rtl/bsa_store.sv -----
module bsa_store
    import bsa_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic [BLK_W-1:0]           rd_blk,
    output logic [SLOTS_PER_BLOCK-1:0] rd_word,
    input  map_wr_t                    wr
);

    // One free word per block; a set bit marks a free slot.
    logic [SLOTS_PER_BLOCK-1:0] free_map_reg [MAX_BLOCKS];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int b = 0; b < MAX_BLOCKS; b++)
            begin
                free_map_reg[b] <= '1;
            end
        end
        else if (wr.en)
        begin
            free_map_reg[wr.blk][wr.idx] <= wr.set;
        end
    end

    assign rd_word = free_map_reg[rd_blk];

endmodule

// ----- rtl/bsa_lsb_unit.sv -----
module bsa_lsb_unit
    import bsa_pkg::*;
(
    input  logic [SLOTS_PER_BLOCK-1:0] word,
    input  logic [WIN_W-1:0]           win,
    output logic                       hit,
    output logic [OFF_W-1:0]           off
);

    logic [LANE_W-1:0] lane;

    assign lane = word[win * LANE_W +: LANE_W];

    // Priority pick of the lowest set bit inside the current window.
    always_comb
    begin
        hit = 1'b0;
        off = '0;
        for (int i = LANE_W - 1; i >= 0; i--)
        begin
            if (lane[i])
            begin
                hit = 1'b1;
                off = OFF_W'(i);
            end
        end
    end

endmodule

// ----- tb/tb_bitmap_slot_allocator.sv -----
`timescale 1ns / 1ps

module tb_bitmap_slot_allocator;
    import bsa_pkg::*;

    // Generous cycle budget for a run of at most 1765 requests.
    localparam int CYCLE_LIMIT = 400000;
    localparam int TOTAL_SLOTS = MAX_BLOCKS * SLOTS_PER_BLOCK;

    // Scoreboard: it keeps its own copy of the free map, the open block count
    // and the live count. Each accepted request is run through that copy, and
    // the response it should cause is queued. Responses from the block are
    // checked in order against that queue.
    class slot_scoreboard;
        logic [SLOTS_PER_BLOCK-1:0] free_word [MAX_BLOCKS];
        int   blocks_open;
        int   slots_used;
        rsp_t expected_q [$];
        int   mismatches;
        int   grants;
        int   full_refusals;
        int   frees_ok;
        int   bad_frees;

        function new();
            for (int b = 0; b < MAX_BLOCKS; b++)
            begin
                free_word[b] = '1;
            end
            blocks_open   = 1;
            slots_used    = 0;
            mismatches    = 0;
            grants        = 0;
            full_refusals = 0;
            frees_ok      = 0;
            bad_frees     = 0;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function bit slot_in_use(int s);
            return (s / SLOTS_PER_BLOCK < blocks_open) &&
                   !free_word[s / SLOTS_PER_BLOCK][s % SLOTS_PER_BLOCK];
        endfunction

        // Returns a slot that is currently allocated, or any slot when none is.
        function logic [SLOT_W-1:0] pick_in_use();
            int s;
            int first;
            if (slots_used == 0)
            begin
                return SLOT_W'($urandom_range(0, TOTAL_SLOTS - 1));
            end
            for (int t = 0; t < 64; t++)
            begin
                s = $urandom_range(0, blocks_open * SLOTS_PER_BLOCK - 1);
                if (slot_in_use(s))
                begin
                    return SLOT_W'(s);
                end
            end
            first = $urandom_range(0, TOTAL_SLOTS - 1);
            for (int k = 0; k < TOTAL_SLOTS; k++)
            begin
                s = (first + k) % TOTAL_SLOTS;
                if (slot_in_use(s))
                begin
                    return SLOT_W'(s);
                end
            end
            return SLOT_W'(first);
        endfunction

        function void note_request(req_t r);
            rsp_t o;
            int   chosen;
            int   idx;
            int   blk;
            o        = '0;
            o.status = STATUS_OK;
            if (r.command == CMD_ALLOC)
            begin
                // Search from the newest open block back toward block zero.
                chosen = -1;
                for (int b = blocks_open - 1; b >= 0; b--)
                begin
                    if (chosen < 0 && free_word[b] != '0)
                    begin
                        chosen = b;
                    end
                end
                if (chosen < 0)
                begin
                    if (blocks_open < MAX_BLOCKS)
                    begin
                        chosen = blocks_open;
                        free_word[chosen] = '1;
                        blocks_open++;
                    end
                    else
                    begin
                        o.status = STATUS_FULL;
                        full_refusals++;
                    end
                end
                if (chosen >= 0)
                begin
                    idx = -1;
                    for (int i = 0; i < SLOTS_PER_BLOCK; i++)
                    begin
                        if (idx < 0 && free_word[chosen][i])
                        begin
                            idx = i;
                        end
                    end
                    free_word[chosen][idx] = 1'b0;
                    o.granted_slot = SLOT_W'(chosen * SLOTS_PER_BLOCK + idx);
                    slots_used++;
                    grants++;
                end
            end
            else
            begin
                blk = int'(r.slot) / SLOTS_PER_BLOCK;
                idx = int'(r.slot) % SLOTS_PER_BLOCK;
                if (blk >= blocks_open || free_word[blk][idx])
                begin
                    o.status = STATUS_BAD;
                    bad_frees++;
                end
                else
                begin
                    free_word[blk][idx] = 1'b1;
                    slots_used--;
                    frees_ok++;
                end
            end
            o.live_count  = LIVE_W'(slots_used);
            o.open_blocks = OPEN_W'(blocks_open);
            expected_q.push_back(o);
        endfunction

        function void check_result(rsp_t got);
            rsp_t want;
            if (expected_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                begin
                    $display("%0t: response with no request outstanding: slot %0d status %0d",
                             $realtime, got.granted_slot, got.status);
                end
                return;
            end
            want = expected_q.pop_front();
            if (got.granted_slot !== want.granted_slot || got.status !== want.status ||
                got.live_count !== want.live_count || got.open_blocks !== want.open_blocks)
            begin
                mismatches++;
                if (mismatches <= 10)
                begin
                    $display("%0t: expected slot %0d status %0d live %0d open %0d", $realtime,
                             want.granted_slot, want.status, want.live_count,
                             want.open_blocks);
                    $display("%0t:      got slot %0d status %0d live %0d open %0d", $realtime,
                             got.granted_slot, got.status, got.live_count, got.open_blocks);
                end
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    logic start;
    req_t request;
    logic busy;
    logic done;
    rsp_t result;

    slot_scoreboard sb;
    int  cycle_count;
    // Mirrors the value last scheduled on start, so that start is never given
    // two nonblocking assignments in one time step.
    bit  start_on;

    bitmap_slot_allocator dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .request (request),
        .busy    (busy),
        .done    (done),
        .result  (result)
    );

    always #1 clk = ~clk;

    // The timeout guards against a hung handshake.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles.", cycle_count);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // A response is valid only in the cycle where done is high, and it is
    // sampled on the edge that ends that cycle.
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            sb.check_result(result);
        end
    end

    // Presents one request and holds it until the block takes it, that is until
    // an edge where start is high and busy is low. Afterwards the sender may go
    // quiet for a while; a long gap now and then lets an allocate finish its
    // whole block and window walk with nothing waiting.
    task automatic send_request(input req_t r, input int idle_pct);
        int gap;
        start_on = 1'b1;
        start   <= 1'b1;
        request <= r;
        do @(posedge clk); while (busy);
        sb.note_request(r);
        if ($urandom_range(0, 99) < idle_pct)
        begin
            gap = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 30) : $urandom_range(1, 8);
            start_on = 1'b0;
            start   <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Stops sending and waits until every outstanding response has arrived.
    task automatic wait_until_drained();
        if (start_on)
        begin
            start_on = 1'b0;
            start   <= 1'b0;
        end
        while (sb.pending() != 0) @(posedge clk);
    endtask

    function automatic req_t make_cmd(input logic c, input int s);
        req_t r;
        r.command = c;
        r.slot    = SLOT_W'(s);
        return r;
    endfunction

    // Builds a random request. Allocates carry a random slot field, which the
    // block has to ignore. Most frees target a slot in use; the rest are a
    // slot somewhere in the open blocks (often already free) or any slot at
    // all, which often lies beyond the open blocks.
    function automatic req_t make_random(input int alloc_pct);
        req_t r;
        int   k;
        r.slot = SLOT_W'($urandom_range(0, TOTAL_SLOTS - 1));
        if ($urandom_range(0, 99) < alloc_pct)
        begin
            r.command = CMD_ALLOC;
        end
        else
        begin
            r.command = CMD_FREE;
            k = $urandom_range(0, 9);
            if (k < 8)
            begin
                r.slot = sb.pick_in_use();
            end
            else if (k == 8)
            begin
                r.slot = SLOT_W'($urandom_range(0, sb.blocks_open * SLOTS_PER_BLOCK - 1));
            end
        end
        return r;
    endfunction

    initial
    begin
        int n;
        sb          = new();
        clk         = 1'b0;
        rst_n       = 1'b0;
        start       = 1'b0;
        start_on    = 1'b0;
        request     = '0;
        cycle_count = 0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed requests on a fresh store: the first grants, a free of a
        // slot that is already free, frees beyond the single open block, the
        // slot field at all ones and at alternating patterns.
        send_request(make_cmd(CMD_ALLOC, 0), 24);
        send_request(make_cmd(CMD_ALLOC, TOTAL_SLOTS - 1), 24);
        send_request(make_cmd(CMD_FREE, 0), 24);
        send_request(make_cmd(CMD_FREE, 0), 24);
        send_request(make_cmd(CMD_FREE, TOTAL_SLOTS - 1), 24);
        send_request(make_cmd(CMD_FREE, SLOTS_PER_BLOCK), 24);
        send_request(make_cmd(CMD_ALLOC, 10'h155), 0);
        send_request(make_cmd(CMD_ALLOC, 10'h2AA), 0);
        send_request(make_cmd(CMD_FREE, 1), 0);
        send_request(make_cmd(CMD_FREE, 10'h2AA), 0);
        send_request(make_cmd(CMD_FREE, 10'h155), 0);
        send_request(make_cmd(CMD_FREE, 0), 0);
        send_request(make_cmd(CMD_FREE, 2), 0);
        send_request(make_cmd(CMD_FREE, 63), 0);
        send_request(make_cmd(CMD_ALLOC, 0), 0);
        wait_until_drained();

        // Mixed traffic, with a sender gap after about a quarter of the requests.
        for (n = 0; n < 100; n++)
        begin
            send_request(make_random(55), 24);
        end
        wait_until_drained();

        // Fill the store with mostly allocates and a few frees, so that holes
        // open in older blocks and the backward search has to walk past full
        // blocks. Keep going until the full store has refused 12 allocates or 1500
        // requests have been sent. The sender pauses after most requests here.
        n = 0;
        while (sb.full_refusals < 12 && n < 1500)
        begin
            send_request(make_random(94), 82);
            n++;
            if (n % 400 == 0)
            begin
                wait_until_drained();
            end
        end
        wait_until_drained();

        // Mostly frees, back to back with no sender gaps.
        for (n = 0; n < 150; n++)
        begin
            send_request(make_random(15), 0);
        end

        wait_until_drained();
        repeat (40) @(posedge clk);

        $display("Covered %0d grants, %0d full-store refusals, %0d frees, %0d bad frees.",
                 sb.grants, sb.full_refusals, sb.frees_ok, sb.bad_frees);
        $display("Blocks open at the end: %0d, slots live: %0d, mismatches: %0d.",
                 sb.blocks_open, sb.slots_used, sb.mismatches);
        if (sb.mismatches == 0 && sb.pending() == 0)
        begin
            $display("SCOREBOARD CLEAN");
        end
        else
        begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

// ----- files.f -----
rtl/bsa_pkg.sv
rtl/bsa_store.sv
rtl/bsa_lsb_unit.sv
rtl/bitmap_slot_allocator.sv
tb/tb_bitmap_slot_allocator.sv
